[src/oramc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oramc_pkg
// Shared constants, command codes and control structs of the oblivious
// storage controller.
// ----------------------------------------------------------------------------
package oramc_pkg;

	// default sizes of the tree, stash and block space
	localparam int LEAVES_DEF      = 8;
	localparam int SLOTS_DEF       = 7;
	localparam int STASH_DEF       = 64;
	localparam int NUM_BLOCKS_DEF  = 64;
	localparam int DATA_WIDTH_DEF  = 32;

	// fixed widths of the channel fields
	localparam int ID_IN_W   = 6;
	localparam int LEAF_IN_W = 3;
	localparam int DATA_IO_W = 32;
	localparam int CFG_W     = 8;

	// number of input codes reduced by the id and leaf tables
	localparam int ID_CODES   = 1 << ID_IN_W;
	localparam int LEAF_CODES = 1 << LEAF_IN_W;

	// reset value of the eviction interval
	localparam logic [CFG_W-1:0] INTERVAL_RST = CFG_W'(1);

	// datapath operations issued by the controller
	typedef enum logic [4:0] {
		OP_NONE     = 5'd0,
		OP_ACCEPT   = 5'd1,
		OP_MAP      = 5'd2,
		OP_PATH     = 5'd3,
		OP_FETCH_RD = 5'd4,
		OP_FETCH_WR = 5'd5,
		OP_FIND_RD  = 5'd6,
		OP_FIND_CMP = 5'd7,
		OP_HIT      = 5'd8,
		OP_MISS     = 5'd9,
		OP_EVCHK    = 5'd10,
		OP_LVL_INIT = 5'd11,
		OP_EV_RD    = 5'd12,
		OP_MEET_INIT = 5'd13,
		OP_MEET     = 5'd14,
		OP_PLACE    = 5'd15,
		OP_SH_RD    = 5'd16,
		OP_SH_WR    = 5'd17,
		OP_CP_RD    = 5'd18,
		OP_CP_WR    = 5'd19,
		OP_LVL_END  = 5'd20,
		OP_DONE     = 5'd21
	} op_t;

	typedef struct packed {
		op_t  op;
		logic in_ready;
	} cmd_t;

	typedef struct packed {
		logic act;
		logic map_vld;
		logic map_was;
		logic path_last;
		logic fetch_last;
		logic find_none;
		logic hit;
		logic ev_due;
		logic scan_end;
		logic meet_eq;
		logic sh_end;
		logic cp_end;
		logic lvl_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

[src/oramc_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oramc_ifs
// Request and response channels of the oblivious storage controller.
// ----------------------------------------------------------------------------
interface oramc_in_if import oramc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 action;
	logic [ID_IN_W-1:0]   block_id;
	logic [DATA_IO_W-1:0] write_data;
	logic [LEAF_IN_W-1:0] new_leaf;

	modport source (output valid, output action, output block_id, output write_data,
		output new_leaf, input ready);
	modport sink (input valid, input action, input block_id, input write_data,
		input new_leaf, output ready);
endinterface

interface oramc_out_if import oramc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [DATA_IO_W-1:0] read_data;
	logic                 found;
	logic                 stash_full;

	modport source (output valid, output read_data, output found, output stash_full,
		input ready);
	modport sink (input valid, input read_data, input found, input stash_full,
		output ready);
endinterface
`default_nettype wire

[src/oramc_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oramc_ctrl
// Sequencer of one access: map lookup, path fetch, stash search, update and
// periodic path eviction, one datapath op per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module oramc_ctrl import oramc_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  req_valid,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [18:0] {
		S_IDLE      = 19'h00001,
		S_MAP       = 19'h00002,
		S_PATH      = 19'h00004,
		S_FETCH_RD  = 19'h00008,
		S_FETCH_WR  = 19'h00010,
		S_FIND_RD   = 19'h00020,
		S_FIND_CMP  = 19'h00040,
		S_HIT       = 19'h00080,
		S_MISS      = 19'h00100,
		S_EVCHK     = 19'h00200,
		S_LVL       = 19'h00400,
		S_EV_RD     = 19'h00800,
		S_MEET_INIT = 19'h01000,
		S_MEET      = 19'h02000,
		S_PLACE     = 19'h04000,
		S_SH        = 19'h08000,
		S_CP        = 19'h10000,
		S_LVL_END   = 19'h20000,
		S_DONE      = 19'h40000
	} state_t;

	state_t state_q, state_d;
	logic   evict_q, evict_d;
	logic   wr_phase_q, wr_phase_d;

	// next state and operation
	always_comb begin
		state_d    = state_q;
		evict_d    = evict_q;
		wr_phase_d = wr_phase_q;
		cmd.op     = OP_NONE;
		cmd.in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (req_valid) begin
					cmd.op  = OP_ACCEPT;
					state_d = S_MAP;
				end
			end
			S_MAP: begin
				cmd.op  = OP_MAP;
				evict_d = 1'b0;
				if (!sts.act && !sts.map_vld) begin
					state_d = S_EVCHK;
				end else begin
					state_d = S_PATH;
				end
			end
			S_PATH: begin
				cmd.op = OP_PATH;
				if (sts.path_last) begin
					state_d = S_FETCH_RD;
				end
			end
			S_FETCH_RD: begin
				cmd.op  = OP_FETCH_RD;
				state_d = S_FETCH_WR;
			end
			S_FETCH_WR: begin
				cmd.op = OP_FETCH_WR;
				if (!sts.fetch_last) begin
					state_d = S_FETCH_RD;
				end else if (evict_q) begin
					state_d = S_LVL;
				end else if (sts.act && !sts.map_was) begin
					state_d = S_MISS;
				end else begin
					state_d = S_FIND_RD;
				end
			end
			S_FIND_RD: begin
				cmd.op  = OP_FIND_RD;
				state_d = sts.find_none ? S_MISS : S_FIND_CMP;
			end
			S_FIND_CMP: begin
				cmd.op  = OP_FIND_CMP;
				state_d = sts.hit ? S_HIT : S_FIND_RD;
			end
			S_HIT: begin
				cmd.op  = OP_HIT;
				state_d = S_EVCHK;
			end
			S_MISS: begin
				cmd.op  = OP_MISS;
				state_d = S_EVCHK;
			end
			S_EVCHK: begin
				cmd.op = OP_EVCHK;
				if (sts.ev_due) begin
					evict_d = 1'b1;
					state_d = S_PATH;
				end else begin
					state_d = S_DONE;
				end
			end
			S_LVL: begin
				cmd.op  = OP_LVL_INIT;
				state_d = S_EV_RD;
			end
			S_EV_RD: begin
				cmd.op     = OP_EV_RD;
				wr_phase_d = 1'b0;
				state_d    = sts.scan_end ? S_SH : S_MEET_INIT;
			end
			S_MEET_INIT: begin
				cmd.op  = OP_MEET_INIT;
				state_d = S_MEET;
			end
			S_MEET: begin
				cmd.op = OP_MEET;
				if (sts.meet_eq) begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				cmd.op  = OP_PLACE;
				state_d = S_EV_RD;
			end
			// shift the unexamined prefix up, read and write in turn
			S_SH: begin
				if (wr_phase_q) begin
					cmd.op     = OP_SH_WR;
					wr_phase_d = 1'b0;
				end else begin
					cmd.op = OP_SH_RD;
					if (sts.sh_end) begin
						state_d = S_CP;
					end else begin
						wr_phase_d = 1'b1;
					end
				end
			end
			// copy the kept blocks to the front
			S_CP: begin
				if (wr_phase_q) begin
					cmd.op     = OP_CP_WR;
					wr_phase_d = 1'b0;
				end else begin
					cmd.op = OP_CP_RD;
					if (sts.cp_end) begin
						state_d = S_LVL_END;
					end else begin
						wr_phase_d = 1'b1;
					end
				end
			end
			S_LVL_END: begin
				cmd.op  = OP_LVL_END;
				state_d = sts.lvl_last ? S_DONE : S_LVL;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.op  = OP_DONE;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			evict_q    <= 1'b0;
			wr_phase_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			evict_q    <= evict_d;
			wr_phase_q <= wr_phase_d;
		end
	end

endmodule
`default_nettype wire

[src/oramc_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oramc_dp
// Datapath: leaf map, bucket tree, ordered stash, scratch buffer, path and
// common-ancestor walkers, loop counters and the result register.
// ----------------------------------------------------------------------------
module oramc_dp import oramc_pkg::*; #(
	parameter int LEAVES           = LEAVES_DEF,
	parameter int SLOTS_PER_BUCKET = SLOTS_DEF,
	parameter int STASH_DEPTH      = STASH_DEF,
	parameter int NUM_BLOCKS       = NUM_BLOCKS_DEF,
	parameter int DATA_WIDTH       = DATA_WIDTH_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  wire                  cfg_wr_en,
	input  wire [CFG_W-1:0]      cfg_wr_data,
	input  wire                  in_action,
	input  wire [ID_IN_W-1:0]    in_block_id,
	input  wire [DATA_IO_W-1:0]  in_write_data,
	input  wire [LEAF_IN_W-1:0]  in_new_leaf,
	input  wire                  out_ready,
	output logic                 out_valid,
	output logic [DATA_IO_W-1:0] out_read_data,
	output logic                 out_found,
	output logic                 out_stash_full
);

	localparam int IW    = $clog2(NUM_BLOCKS);
	localparam int LW    = $clog2(LEAVES);
	localparam int NODES = 2 * LEAVES - 1;
	localparam int NW    = $clog2(NODES);
	localparam int NSL   = NODES * SLOTS_PER_BUCKET;
	localparam int TAW   = $clog2(NSL);
	localparam int PCAP  = NW;
	localparam int PIW   = $clog2(PCAP);
	localparam int LENW  = $clog2(PCAP + 1);
	localparam int SIW   = $clog2(STASH_DEPTH);
	localparam int CW    = $clog2(STASH_DEPTH + 1);
	localparam int FW    = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int DW    = DATA_WIDTH;
	localparam int EW    = IW + LW + DW;

	// input reduction tables, built at elaboration
	function automatic logic [ID_CODES*IW-1:0] id_tab();
		logic [ID_CODES*IW-1:0] t;
		int r;
		t = '0;
		for (int v = 0; v < ID_CODES; v++) begin
			r = v;
			for (int k = 0; k < ID_CODES; k++) begin
				if (r >= NUM_BLOCKS) r = r - NUM_BLOCKS;
			end
			t[v*IW +: IW] = IW'(r);
		end
		return t;
	endfunction

	function automatic logic [LEAF_CODES*LW-1:0] leaf_tab();
		logic [LEAF_CODES*LW-1:0] t;
		int r;
		t = '0;
		for (int v = 0; v < LEAF_CODES; v++) begin
			r = v;
			for (int k = 0; k < LEAF_CODES; k++) begin
				if (r >= LEAVES) r = r - LEAVES;
			end
			t[v*LW +: LW] = LW'(r);
		end
		return t;
	endfunction

	localparam logic [ID_CODES*IW-1:0]   ID_TAB   = id_tab();
	localparam logic [LEAF_CODES*LW-1:0] LEAF_TAB = leaf_tab();

	function automatic logic [NW-1:0] up_node(input logic [NW-1:0] n);
		return (n == '0) ? '0 : NW'((n - NW'(1)) >> 1);
	endfunction

	function automatic logic [NW-1:0] leaf_node(input logic [LW-1:0] l);
		return NW'(LEAVES - 1) + NW'(l);
	endfunction

	function automatic logic [TAW-1:0] slot_addr(input logic [NW-1:0] n,
		input logic [FW-1:0] s);
		return TAW'(TAW'(n) * TAW'(SLOTS_PER_BUCKET) + TAW'(s));
	endfunction

	// entry layout: id, leaf, data
	function automatic logic [IW-1:0] e_id(input logic [EW-1:0] e);
		return e[EW-1 -: IW];
	endfunction

	function automatic logic [LW-1:0] e_leaf(input logic [EW-1:0] e);
		return e[DW +: LW];
	endfunction

	function automatic logic [DW-1:0] e_data(input logic [EW-1:0] e);
		return e[DW-1:0];
	endfunction

	// memories
	logic [LW-1:0] lmap_mem [NUM_BLOCKS];
	logic [EW-1:0] tree_mem [NSL];
	logic [EW-1:0] stash_mem [STASH_DEPTH];
	logic [EW-1:0] scr_mem [STASH_DEPTH];

	// control state
	logic            lmap_vld_q [NUM_BLOCKS];
	logic            tree_vld_q [NSL];
	logic [CW-1:0]   cnt_q;
	logic [CFG_W-1:0] acc_cnt_q;
	logic [CFG_W-1:0] interval_q;
	logic [LW-1:0]   evict_leaf_q;
	logic            out_vld_q;

	// payload and loop registers
	logic            act_q;
	logic [IW-1:0]   id_q;
	logic [DW-1:0]   wdata_q;
	logic [LW-1:0]   nl_q;
	logic            map_was_q;
	logic            found_q;
	logic            dropped_q;
	logic [DW-1:0]   rd_q;
	logic [LW-1:0]   lmap_rd_q;
	logic [EW-1:0]   tree_rd_q;
	logic            tvld_s1;
	logic [EW-1:0]   stash_rd_q;
	logic [EW-1:0]   scr_rd_q;
	logic [NW-1:0]   path_q [PCAP];
	logic [LENW-1:0] len_q;
	logic [NW-1:0]   nd_q;
	logic [PIW-1:0]  lvl_q;
	logic [FW-1:0]   slot_q;
	logic [FW-1:0]   fill_q;
	logic [CW-1:0]   j_q;
	logic [CW-1:0]   i_q;
	logic [CW-1:0]   kept_q;
	logic [NW-1:0]   ma_q;
	logic [NW-1:0]   mb_q;
	logic [EW-1:0]   e_q;

	// derived values
	logic [IW-1:0]   in_id;
	logic [LW-1:0]   in_leaf;
	logic [NW-1:0]   cur_node;
	logic [TAW-1:0]  fetch_addr;
	logic [TAW-1:0]  place_addr;
	logic            stash_room;
	logic            place_ok;
	logic [LW-1:0]   fetch_leaf;
	logic [EW-1:0]   new_entry;
	logic [CW-1:0]   cp_src;
	logic [CW-1:0]   sh_dst;

	assign in_id      = ID_TAB[int'(in_block_id)*IW +: IW];
	assign in_leaf    = LEAF_TAB[int'(in_new_leaf)*LW +: LW];
	assign cur_node   = path_q[lvl_q];
	assign fetch_addr = slot_addr(cur_node, slot_q);
	assign place_addr = slot_addr(cur_node, fill_q);
	assign stash_room = (cnt_q < CW'(STASH_DEPTH));
	assign place_ok   = (cur_node <= ma_q);
	assign fetch_leaf = (act_q && !lmap_vld_q[id_q]) ? nl_q : lmap_rd_q;
	assign new_entry  = {id_q, nl_q, wdata_q};
	assign cp_src     = kept_q - i_q - CW'(1);
	assign sh_dst     = kept_q + i_q;

	// status to the controller
	always_comb begin
		sts.act        = act_q;
		sts.map_vld    = lmap_vld_q[id_q];
		sts.map_was    = map_was_q;
		sts.path_last  = (nd_q == '0);
		sts.fetch_last = (lvl_q == '0) && (slot_q == FW'(SLOTS_PER_BUCKET - 1));
		sts.find_none  = (i_q == cnt_q);
		sts.hit        = (e_id(stash_rd_q) == id_q);
		sts.ev_due     = (acc_cnt_q >= interval_q);
		sts.scan_end   = (j_q == '0) || (fill_q == FW'(SLOTS_PER_BUCKET));
		sts.meet_eq    = (ma_q == mb_q);
		sts.sh_end     = (i_q == '0) || (kept_q == '0);
		sts.cp_end     = (i_q == kept_q);
		sts.lvl_last   = (LENW'(lvl_q) == len_q - LENW'(1));
		sts.out_free   = !out_vld_q || out_ready;
	end

	// stash port selection: one read and one write per cycle
	logic            st_we;
	logic [SIW-1:0]  st_wa;
	logic [EW-1:0]   st_wd;
	logic            st_re;
	logic [SIW-1:0]  st_ra;

	always_comb begin
		st_we = 1'b0;
		st_wa = cnt_q[SIW-1:0];
		st_wd = new_entry;
		st_re = 1'b0;
		st_ra = i_q[SIW-1:0];
		case (cmd.op)
			OP_FETCH_WR: begin
				st_we = tvld_s1 && stash_room;
				st_wd = tree_rd_q;
			end
			OP_MISS: begin
				st_we = act_q && stash_room;
			end
			OP_HIT: begin
				st_we = 1'b1;
				st_wa = i_q[SIW-1:0];
				st_wd = {id_q, nl_q, act_q ? wdata_q : e_data(stash_rd_q)};
			end
			OP_SH_WR: begin
				st_we = 1'b1;
				st_wa = sh_dst[SIW-1:0];
				st_wd = stash_rd_q;
			end
			OP_CP_WR: begin
				st_we = 1'b1;
				st_wa = i_q[SIW-1:0];
				st_wd = scr_rd_q;
			end
			OP_FIND_RD: begin
				st_re = !sts.find_none;
			end
			OP_EV_RD: begin
				st_re = !sts.scan_end;
				st_ra = SIW'(j_q - CW'(1));
			end
			OP_SH_RD: begin
				st_re = !sts.sh_end;
				st_ra = SIW'(i_q - CW'(1));
			end
			default: begin
			end
		endcase
	end

	// stash and scratch memories
	always_ff @(posedge clk) begin
		if (st_we) begin
			stash_mem[st_wa] <= st_wd;
		end
		if (st_re) begin
			stash_rd_q <= stash_mem[st_ra];
		end
		if (cmd.op == OP_PLACE && !place_ok) begin
			scr_mem[kept_q[SIW-1:0]] <= e_q;
		end
		if (cmd.op == OP_CP_RD && !sts.cp_end) begin
			scr_rd_q <= scr_mem[cp_src[SIW-1:0]];
		end
	end

	// tree memory
	always_ff @(posedge clk) begin
		if (cmd.op == OP_PLACE && place_ok) begin
			tree_mem[place_addr] <= e_q;
		end
		if (cmd.op == OP_FETCH_RD) begin
			tree_rd_q <= tree_mem[fetch_addr];
		end
	end

	// leaf map memory
	always_ff @(posedge clk) begin
		if ((cmd.op == OP_MAP && act_q) || (cmd.op == OP_HIT && !act_q)) begin
			lmap_mem[id_q] <= nl_q;
		end
		if (cmd.op == OP_ACCEPT) begin
			lmap_rd_q <= lmap_mem[in_id];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BLOCKS; b++) lmap_vld_q[b] <= 1'b0;
			for (int s = 0; s < NSL; s++) tree_vld_q[s] <= 1'b0;
			cnt_q        <= '0;
			acc_cnt_q    <= '0;
			interval_q   <= INTERVAL_RST;
			evict_leaf_q <= LW'(LEAVES - 1);
			out_vld_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				interval_q <= cfg_wr_data;
			end
			// result valid: set on load, cleared when taken
			if (cmd.op == OP_DONE) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && out_ready) begin
				out_vld_q <= 1'b0;
			end
			case (cmd.op)
				OP_ACCEPT: begin
					acc_cnt_q <= acc_cnt_q + CFG_W'(1);
				end
				OP_MAP: begin
					if (act_q) lmap_vld_q[id_q] <= 1'b1;
				end
				OP_FETCH_RD: begin
					tree_vld_q[fetch_addr] <= 1'b0;
				end
				OP_FETCH_WR: begin
					if (tvld_s1 && stash_room) cnt_q <= cnt_q + CW'(1);
				end
				OP_MISS: begin
					if (!act_q) begin
						lmap_vld_q[id_q] <= 1'b0;
					end else if (stash_room) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				OP_EVCHK: begin
					if (sts.ev_due) acc_cnt_q <= '0;
				end
				OP_PLACE: begin
					if (place_ok) tree_vld_q[place_addr] <= 1'b1;
				end
				OP_LVL_END: begin
					cnt_q <= kept_q + j_q;
					if (sts.lvl_last) begin
						evict_leaf_q <= (evict_leaf_q == '0) ? LW'(LEAVES - 1)
							: evict_leaf_q - LW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload, walkers and loop counters
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: begin
				act_q     <= in_action;
				id_q      <= in_id;
				wdata_q   <= DW'(in_write_data);
				nl_q      <= in_leaf;
				found_q   <= 1'b0;
				dropped_q <= 1'b0;
				rd_q      <= '0;
			end
			OP_MAP: begin
				map_was_q <= lmap_vld_q[id_q];
				nd_q      <= leaf_node(fetch_leaf);
				len_q     <= '0;
				i_q       <= '0;
			end
			OP_PATH: begin
				path_q[len_q[PIW-1:0]] <= nd_q;
				len_q <= len_q + LENW'(1);
				nd_q  <= up_node(nd_q);
				if (nd_q == '0) begin
					lvl_q  <= len_q[PIW-1:0];
					slot_q <= '0;
				end
			end
			OP_FETCH_RD: begin
				tvld_s1 <= tree_vld_q[fetch_addr];
			end
			OP_FETCH_WR: begin
				if (tvld_s1 && !stash_room) dropped_q <= 1'b1;
				if (!sts.fetch_last) begin
					if (slot_q == FW'(SLOTS_PER_BUCKET - 1)) begin
						slot_q <= '0;
						lvl_q  <= lvl_q - PIW'(1);
					end else begin
						slot_q <= slot_q + FW'(1);
					end
				end
			end
			OP_FIND_CMP: begin
				if (!sts.hit) i_q <= i_q + CW'(1);
			end
			OP_HIT: begin
				found_q <= 1'b1;
				rd_q    <= act_q ? '0 : e_data(stash_rd_q);
			end
			OP_MISS: begin
				if (act_q && !stash_room) dropped_q <= 1'b1;
			end
			OP_EVCHK: begin
				nd_q  <= leaf_node(evict_leaf_q);
				len_q <= '0;
			end
			OP_LVL_INIT: begin
				j_q    <= cnt_q;
				fill_q <= '0;
				kept_q <= '0;
			end
			OP_EV_RD: begin
				if (sts.scan_end) begin
					i_q <= j_q;
				end else begin
					j_q <= j_q - CW'(1);
				end
			end
			OP_MEET_INIT: begin
				e_q  <= stash_rd_q;
				ma_q <= leaf_node(e_leaf(stash_rd_q));
				mb_q <= leaf_node(evict_leaf_q);
			end
			OP_MEET: begin
				if (ma_q > mb_q) begin
					ma_q <= up_node(ma_q);
				end else if (mb_q > ma_q) begin
					mb_q <= up_node(mb_q);
				end
			end
			OP_PLACE: begin
				if (place_ok) begin
					fill_q <= fill_q + FW'(1);
				end else begin
					kept_q <= kept_q + CW'(1);
				end
			end
			OP_SH_RD: begin
				if (sts.sh_end) begin
					i_q <= '0;
				end else begin
					i_q <= i_q - CW'(1);
				end
			end
			OP_CP_WR: begin
				i_q <= i_q + CW'(1);
			end
			OP_LVL_END: begin
				if (!sts.lvl_last) lvl_q <= lvl_q + PIW'(1);
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.op == OP_DONE) begin
			out_read_data  <= DATA_IO_W'(rd_q);
			out_found      <= found_q;
			out_stash_full <= dropped_q;
		end
	end

	assign out_valid = out_vld_q;

endmodule
`default_nettype wire

[src/oblivious_ram_controller_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oblivious_ram_controller_unit
// Path-based oblivious block store with leaf map, bucket tree and stash.
//
// Requests arrive on req (action, block_id, write_data, new_leaf) with a
// valid/ready handshake; each accepted item yields exactly one item on rsp
// (read_data, found, stash_full). The eviction interval is written through
// cfg_wr_en / cfg_wr_data while the block is idle.
// One item is in flight at a time. An access looks up the leaf map,
// fetches the path bucket by bucket into the stash and searches it; an
// access that also evicts fetches a second path and, per path level,
// scans and rearranges the stash one entry at a time.
// Reset clears the map and tree valid bits, empties the stash, sets the
// interval to one and the eviction leaf to the last leaf; no clearing pass.
// The result waits in an output register; a stalled receiver holds the
// block in its final step and new requests are taken once it is loaded.
// ----------------------------------------------------------------------------
module oblivious_ram_controller_unit import oramc_pkg::*; #(
	parameter int LEAVES           = LEAVES_DEF,
	parameter int SLOTS_PER_BUCKET = SLOTS_DEF,
	parameter int STASH_DEPTH      = STASH_DEF,
	parameter int NUM_BLOCKS       = NUM_BLOCKS_DEF,
	parameter int DATA_WIDTH       = DATA_WIDTH_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             cfg_wr_en,
	input  wire [CFG_W-1:0] cfg_wr_data,
	oramc_in_if.sink        req,
	oramc_out_if.source     rsp
);

	cmd_t cmd;
	sts_t sts;

	// access sequencer
	oramc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	assign req.ready = cmd.in_ready;

	// storage and datapath
	oramc_dp #(
		.LEAVES           (LEAVES),
		.SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
		.STASH_DEPTH      (STASH_DEPTH),
		.NUM_BLOCKS       (NUM_BLOCKS),
		.DATA_WIDTH       (DATA_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_action      (req.action),
		.in_block_id    (req.block_id),
		.in_write_data  (req.write_data),
		.in_new_leaf    (req.new_leaf),
		.out_ready      (rsp.ready),
		.out_valid      (rsp.valid),
		.out_read_data  (rsp.read_data),
		.out_found      (rsp.found),
		.out_stash_full (rsp.stash_full)
	);

endmodule
`default_nettype wire

[tb/tb_oblivious_ram_controller_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_oblivious_ram_controller_unit
// Drives reads and writes into the oblivious block store and checks each
// response against a local model of the leaf map, bucket tree and stash,
// across several eviction intervals, random idling and a long output stall.
// ----------------------------------------------------------------------------
module tb_oblivious_ram_controller_unit;
	import oramc_pkg::*;

	localparam int NLEAF    = LEAVES_DEF;
	localparam int NSLOT    = SLOTS_DEF;
	localparam int NSTASH   = STASH_DEF;
	localparam int NBUCKET  = 2 * NLEAF - 1;
	localparam int PATH_LEN = 4;
	localparam int EXP_DEPTH = 1024;
	localparam bit ACT_RD   = 1'b0;
	localparam bit ACT_WR   = 1'b1;

	typedef struct {
		bit                   vld;
		bit [ID_IN_W-1:0]     id;
		bit [LEAF_IN_W-1:0]   leaf;
		bit [DATA_IO_W-1:0]   data;
	} blk_t;

	typedef struct {
		bit [DATA_IO_W-1:0] read_data;
		bit                 found;
		bit                 stash_full;
	} resp_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;

	oramc_in_if  req_if ();
	oramc_out_if rsp_if ();

	oblivious_ram_controller_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req        (req_if),
		.rsp        (rsp_if)
	);

	// shadow store state
	bit                 map_vld [ID_CODES];
	bit [LEAF_IN_W-1:0] map_leaf [ID_CODES];
	blk_t               tree [NBUCKET*NSLOT];
	blk_t               stash [NSTASH];
	blk_t               spill [NSTASH];
	blk_t               front [NSTASH];
	int                 stash_n;
	bit [7:0]           acc_cnt;
	bit [LEAF_IN_W-1:0] ev_leaf;
	bit [CFG_W-1:0]     interval;
	bit                 dropped;

	// expected responses in order of acceptance
	resp_t exp_buf [EXP_DEPTH];
	int    exp_wr = 0;
	int    exp_rd = 0;
	int    errs;
	int    hold_cycles;
	bit    rx_calm;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog
	initial begin
		#40_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic int parent(int n);
		return (n == 0) ? 0 : (n - 1) / 2;
	endfunction

	function automatic int common_node(int a, int b);
		while (a != b) begin
			if (a > b) a = parent(a);
			else b = parent(b);
		end
		return a;
	endfunction

	// bucket indexes from the root down to the given leaf
	function automatic void leaf_path(bit [LEAF_IN_W-1:0] lf, output int p[PATH_LEN]);
		int n;
		n = NLEAF - 1 + lf;
		for (int i = PATH_LEN - 1; i >= 0; i--) begin
			p[i] = n;
			n = parent(n);
		end
	endfunction

	function automatic void stash_push(blk_t b);
		if (stash_n < NSTASH) begin
			stash[stash_n] = b;
			stash_n++;
		end else begin
			dropped = 1'b1;
		end
	endfunction

	function automatic void pull_path(bit [LEAF_IN_W-1:0] lf);
		int p[PATH_LEN];
		leaf_path(lf, p);
		for (int i = 0; i < PATH_LEN; i++)
			for (int s = 0; s < NSLOT; s++) begin
				if (tree[p[i]*NSLOT+s].vld) stash_push(tree[p[i]*NSLOT+s]);
				tree[p[i]*NSLOT+s] = '{default: 0};
			end
	endfunction

	function automatic int stash_find(bit [ID_IN_W-1:0] id);
		for (int i = 0; i < stash_n; i++)
			if (stash[i].id == id) return i;
		return -1;
	endfunction

	// refill the eviction path leaf first from the back of the stash
	function automatic void evict_step();
		int p[PATH_LEN];
		int target, node, fill, kept, j, n;
		blk_t e;
		target = NLEAF - 1 + ev_leaf;
		pull_path(ev_leaf);
		leaf_path(ev_leaf, p);
		for (int lvl = PATH_LEN - 1; lvl >= 0; lvl--) begin
			node = p[lvl];
			fill = 0;
			kept = 0;
			j = stash_n;
			while (j > 0 && fill < NSLOT) begin
				j--;
				e = stash[j];
				if (node <= common_node(NLEAF - 1 + e.leaf, target)) begin
					tree[node*NSLOT+fill] = e;
					fill++;
				end else begin
					spill[kept] = e;
					kept++;
				end
			end
			n = 0;
			for (int i = kept; i > 0; i--) begin
				stash[j+n] = spill[i-1];
				n++;
			end
			for (int i = 0; i < j; i++) front[i] = stash[i];
			for (int i = 0; i < n; i++) stash[i] = stash[j+i];
			for (int i = 0; i < j; i++) stash[n+i] = front[i];
			stash_n = n + j;
		end
		ev_leaf = (ev_leaf == 0) ? LEAF_IN_W'(NLEAF - 1) : ev_leaf - 1;
	endfunction

	// expected response of one access, updating the shadow state
	function automatic resp_t access_predict(bit act, bit [ID_IN_W-1:0] id,
			bit [DATA_IO_W-1:0] data, bit [LEAF_IN_W-1:0] nl);
		resp_t r;
		blk_t b;
		int k;
		bit [LEAF_IN_W-1:0] old;
		r = '{default: 0};
		dropped = 1'b0;
		acc_cnt = acc_cnt + 1;
		if (act == ACT_RD) begin
			if (map_vld[id]) begin
				pull_path(map_leaf[id]);
				k = stash_find(id);
				if (k >= 0) begin
					r.read_data = stash[k].data;
					stash[k].leaf = nl;
					map_leaf[id] = nl;
					r.found = 1'b1;
				end else begin
					map_vld[id] = 1'b0;
				end
			end
		end else begin
			b = '{vld: 1'b1, id: id, leaf: nl, data: data};
			if (!map_vld[id]) begin
				map_vld[id] = 1'b1;
				map_leaf[id] = nl;
				pull_path(nl);
				stash_push(b);
			end else begin
				old = map_leaf[id];
				map_leaf[id] = nl;
				pull_path(old);
				k = stash_find(id);
				if (k >= 0) begin
					stash[k].data = data;
					stash[k].leaf = nl;
					r.found = 1'b1;
				end else begin
					stash_push(b);
				end
			end
		end
		if (acc_cnt >= interval) begin
			acc_cnt = 0;
			evict_step();
		end
		r.stash_full = dropped;
		return r;
	endfunction

	// send one item, then leave valid high at the next falling edge
	task automatic send_item(bit act, bit [ID_IN_W-1:0] id, bit [DATA_IO_W-1:0] data,
			bit [LEAF_IN_W-1:0] nl);
		int gap;
		gap = ($urandom_range(0, 9) < 6) ? 0 :
			($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid      <= 1'b1;
		req_if.action     <= act;
		req_if.block_id   <= id;
		req_if.write_data <= data;
		req_if.new_leaf   <= nl;
		do @(posedge clk); while (!req_if.ready);
		exp_buf[exp_wr % EXP_DEPTH] = access_predict(act, id, data, nl);
		exp_wr++;
		@(negedge clk);
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		wait (exp_rd == exp_wr);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_interval(bit [CFG_W-1:0] v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		interval = v;
	endtask

	// random access, mostly over a small id pool so hits are common
	task automatic send_random(int id_hi);
		bit [ID_IN_W-1:0] id;
		id = ($urandom_range(0, 9) < 8) ? $urandom_range(0, id_hi) : $urandom_range(0, 63);
		send_item($urandom_range(0, 1), id, $urandom, $urandom_range(0, NLEAF - 1));
	endtask

	// field extremes, unmapped reads, hits and overwrites at interval one
	task automatic test_directed();
		send_item(ACT_RD, 6'd5, 32'hFFFF_FFFF, 3'd7);
		send_item(ACT_WR, 6'd0, 32'h0000_0000, 3'd0);
		send_item(ACT_WR, 6'd63, 32'hFFFF_FFFF, 3'd7);
		send_item(ACT_RD, 6'd0, 32'hFFFF_FFFF, 3'd7);
		send_item(ACT_RD, 6'd63, 32'h0, 3'd0);
		send_item(ACT_WR, 6'd63, 32'hA5A5_5A5A, 3'd3);
		send_item(ACT_RD, 6'd63, 32'h0, 3'd4);
		send_item(ACT_WR, 6'd21, 32'h5555_5555, 3'd1);
		send_item(ACT_WR, 6'd42, 32'hAAAA_AAAA, 3'd6);
		send_item(ACT_RD, 6'd21, 32'h0, 3'd2);
		send_item(ACT_RD, 6'd42, 32'h0, 3'd5);
		send_item(ACT_RD, 6'd0, 32'h0, 3'd7);
		send_item(ACT_RD, 6'd30, 32'h0, 3'd0);
	endtask

	// rare evictions let the stash grow large
	task automatic test_max_interval();
		set_interval(8'd255);
		for (int i = 0; i < 60; i++)
			send_item(ACT_WR, i[5:0], $urandom, $urandom_range(0, NLEAF - 1));
		for (int i = 0; i < 20; i++) send_random(63);
	endtask

	task automatic test_random_intervals();
		bit [CFG_W-1:0] ivs[4] = '{8'd1, 8'd3, 8'd7, 8'd2};
		foreach (ivs[n]) begin
			set_interval(ivs[n]);
			rx_calm = (n == 2);
			for (int i = 0; i < 50; i++) send_random(15);
		end
		rx_calm = 1'b0;
	endtask

	// long receiver stall while requests keep coming
	task automatic test_backpressure();
		set_interval(8'd1);
		hold_cycles = 6000;
		for (int i = 0; i < 12; i++) send_random(15);
	endtask

	// response ready with random stalls or a long hold-off
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				rsp_if.ready <= 1'b0;
				hold_cycles--;
			end else if (rx_calm) begin
				rsp_if.ready <= 1'b1;
			end else if ($urandom_range(0, 49) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(20, 300)) @(negedge clk);
			end else begin
				rsp_if.ready <= ($urandom_range(0, 9) < 7);
			end
		end
	end

	// compare each response with the oldest expectation
	always @(posedge clk) begin
		resp_t e;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (exp_rd == exp_wr) begin
				$error("unexpected response item");
				errs++;
			end else begin
				e = exp_buf[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (rsp_if.read_data !== e.read_data) begin
					$error("read_data expected %h actual %h", e.read_data, rsp_if.read_data);
					errs++;
				end
				if (rsp_if.found !== e.found) begin
					$error("found expected %0d actual %0d", e.found, rsp_if.found);
					errs++;
				end
				if (rsp_if.stash_full !== e.stash_full) begin
					$error("stash_full expected %0d actual %0d", e.stash_full,
						rsp_if.stash_full);
					errs++;
				end
			end
		end
	end

	// test sequence
	initial begin
		errs = 0;
		hold_cycles = 0;
		rx_calm = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		req_if.valid = 1'b0;
		req_if.action = ACT_RD;
		req_if.block_id = '0;
		req_if.write_data = '0;
		req_if.new_leaf = '0;
		foreach (map_vld[i]) begin
			map_vld[i] = 1'b0;
			map_leaf[i] = '0;
		end
		foreach (tree[i]) tree[i] = '{default: 0};
		foreach (stash[i]) stash[i] = '{default: 0};
		stash_n = 0;
		acc_cnt = 0;
		ev_leaf = LEAF_IN_W'(NLEAF - 1);
		interval = INTERVAL_RST;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_max_interval();
		test_random_intervals();
		test_backpressure();
		drain();
		if (errs == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule

[filelist.f]
src/oramc_pkg.sv
src/oramc_ifs.sv
src/oramc_ctrl.sv
src/oramc_dp.sv
src/oblivious_ram_controller_unit.sv
tb/tb_oblivious_ram_controller_unit.sv
